/* hw/rtl/far_pkg.sv */
// far_pkg: shared types and codes for the fraction arithmetic reduce core
// no dependencies
package far_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_RED = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [FieldW-1:0] left_num;
    logic [FieldW-1:0] left_den;
    logic [FieldW-1:0] right_num;
    logic [FieldW-1:0] right_den;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] result_num;
    logic [FieldW-1:0] result_den;
    logic [FieldW-1:0] whole_part;
    logic              den_zero;
  } rsp_t;

  // datapath operation select
  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_MUL1  = 4'd2,
    OP_MUL2  = 4'd3,
    OP_COMB  = 4'd4,
    OP_GINIT = 4'd5,
    OP_GSTEP = 4'd6,
    OP_DINIT = 4'd7,
    OP_DSTEP = 4'd8,
    OP_DSAVE = 4'd9,
    OP_FINAL = 4'd10
  } op_e;

  typedef struct packed {
    op_e  op;
    logic div_sel;  // 0: num / g, 1: den / g; the quotient pass (num / den) also selects with 0
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic g_zero;
  } sts_t;

endpackage

/* hw/rtl/far_ctrl.sv */
// far_ctrl: sequencer for the fraction core
// depends on far_pkg
module far_ctrl
  import far_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MUL1  = 11'b00000000010,
    S_MUL2  = 11'b00000000100,
    S_COMB  = 11'b00000001000,
    S_GINIT = 11'b00000010000,
    S_GCD   = 11'b00000100000,
    S_DINIT = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_DSAVE = 11'b00100000000,
    S_FINAL = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // 0 num/g, 1 den/g, 2 quotient
  logic [1:0] phase, phase_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op = OP_IDLE;
    cmd.div_sel = phase[0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin cmd.op = OP_MUL1; state_next = S_MUL2; end
      S_MUL2: begin cmd.op = OP_MUL2; state_next = S_COMB; end
      S_COMB: begin cmd.op = OP_COMB; state_next = S_GINIT; end
      S_GINIT: begin cmd.op = OP_GINIT; state_next = S_GCD; end
      S_GCD: begin
        cmd.op = OP_GSTEP;
        if (sts.gcd_done) begin
          phase_next = 2'd0;
          state_next = sts.g_zero ? S_FINAL : S_DINIT;
        end
      end
      S_DINIT: begin cmd.op = OP_DINIT; state_next = S_DIV; end
      S_DIV: begin
        cmd.op = OP_DSTEP;
        if (sts.div_done) state_next = S_DSAVE;
      end
      S_DSAVE: begin
        cmd.op = OP_DSAVE;
        phase_next = phase + 2'd1;
        state_next = (phase == 2'd2) ? S_OUT : ((phase == 2'd1) ? S_FINAL : S_DINIT);
      end
      S_FINAL: begin
        cmd.op = OP_FINAL;
        phase_next = 2'd2;
        state_next = sts.g_zero ? S_OUT : S_DINIT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

/* hw/rtl/far_dp.sv */
// far_dp: multiplier, binary gcd and restoring divider for the fraction core
// depends on far_pkg
module far_dp
  import far_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [2:0]       kind;
  logic [WIDTH-1:0] a, b, c, d;
  logic [WIDTH-1:0] p1, p2, num, den;
  logic [WIDTH-1:0] gx, gy, g;
  logic [CntW-1:0]  gshift;
  logic             gdone;
  // divider
  logic [WIDTH-1:0] dq, dr, dd;
  logic [CntW-1:0]  dcnt;

  // width-limited product
  function automatic logic [WIDTH-1:0] mulw(input logic [WIDTH-1:0] x,
                                            input logic [WIDTH-1:0] y);
    logic [2*WIDTH-1:0] p;
    begin
      p = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
      mulw = p[WIDTH-1:0];
    end
  endfunction

  function automatic logic [WIDTH-1:0] ext(input logic [FieldW-1:0] v);
    logic [WIDTH+FieldW-1:0] t;
    begin
      t = {{WIDTH{1'b0}}, v};
      ext = t[WIDTH-1:0];
    end
  endfunction

  function automatic logic [FieldW-1:0] cut(input logic [WIDTH-1:0] v);
    logic [WIDTH+FieldW-1:0] t;
    begin
      t = {{FieldW{1'b0}}, v};
      cut = t[FieldW-1:0];
    end
  endfunction

  logic [WIDTH-1:0] diff;
  logic             even_both;

  always_comb begin
    even_both = ~gx[0] & ~gy[0];
    diff = (gx > gy) ? (gx - gy) : (gy - gx);
  end

  logic [WIDTH:0] rem_sh;
  always_comb rem_sh = {dr, dq[WIDTH-1]};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind <= req.kind;
        a <= ext(req.left_num);
        b <= ext(req.left_den);
        c <= ext(req.right_num);
        d <= ext(req.right_den);
      end
      OP_MUL1: begin
        case (kind)
          KIND_ADD, KIND_SUB, KIND_DIV: p1 <= mulw(a, d);
          KIND_MUL: p1 <= mulw(a, c);
          default: p1 <= a;
        endcase
      end
      OP_MUL2: begin
        p2 <= mulw(c, b);
        case (kind)
          KIND_DIV: den <= mulw(b, c);
          KIND_ADD, KIND_SUB, KIND_MUL: den <= mulw(b, d);
          default: den <= b;
        endcase
      end
      OP_COMB: begin
        case (kind)
          KIND_ADD: num <= p1 + p2;
          KIND_SUB: num <= p1 - p2;
          default: num <= p1;
        endcase
      end
      OP_GINIT: begin
        gx <= num;
        gy <= den;
        gshift <= '0;
        gdone <= 1'b0;
      end
      OP_GSTEP: begin
        if (gx == '0) begin
          g <= gy << gshift; gdone <= 1'b1;
        end else if (gy == '0) begin
          g <= gx << gshift; gdone <= 1'b1;
        end else if (even_both) begin
          gx <= gx >> 1; gy <= gy >> 1; gshift <= gshift + 1'b1;
        end else if (~gx[0]) begin
          gx <= gx >> 1;
        end else if (~gy[0]) begin
          gy <= gy >> 1;
        end else if (gx == gy) begin
          g <= gx << gshift; gdone <= 1'b1;
        end else if (gx > gy) begin
          gx <= diff >> 1;
        end else begin
          gy <= diff >> 1;
        end
      end
      OP_DINIT: begin
        // phase 0: num/g, 1: den/g, 2: num/den
        dr <= '0;
        dcnt <= '0;
        dq <= (cmd.div_sel) ? den : num;
        dd <= gdone ? g : den;
      end
      OP_DSTEP: begin
        if (rem_sh >= {1'b0, dd}) begin
          dr <= rem_sh[WIDTH-1:0] - dd;
          dq <= {dq[WIDTH-2:0], 1'b1};
        end else begin
          dr <= rem_sh[WIDTH-1:0];
          dq <= {dq[WIDTH-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      OP_DSAVE: begin
        if (!gdone) rsp.whole_part <= cut(dq);
        else if (cmd.div_sel) den <= dq;
        else num <= dq;
      end
      OP_FINAL: begin
        // reduced pair is final; set up quotient pass
        rsp.result_num <= cut(num);
        rsp.result_den <= cut(den);
        rsp.den_zero   <= (den == '0);
        rsp.whole_part <= '0;
        gdone <= (den == '0);
      end
      default: ;
    endcase
  end

  // g_zero doubles as: after gcd, g==0 ; at final, den==0 (skip quotient)
  assign sts.gcd_done = gdone;
  assign sts.div_done = (dcnt == CntW'(WIDTH - 1));
  assign sts.g_zero   = (cmd.op == OP_FINAL) ? (den == '0) : (g == '0);

endmodule

/* hw/rtl/fraction_arith_reduce_core.sv */
// fraction_arith_reduce_core: top level of the rational alu with gcd reduction
// depends on far_pkg, far_ctrl, far_dp
//
//   channel | valid     | stall     | payload
//   request | in_valid  | in_stall  | in  (req_t)
//   result  | out_valid | out_stall | out (rsp_t)
//
// one request at a time; multiply and setup, then a binary gcd, then up to
// three restoring divisions (num/g, den/g, num/den)
// rst is synchronous, clears the controller only
// the result is held until out_stall is low; no new request until then
module fraction_arith_reduce_core
  import far_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out
);

  cmd_t cmd;
  sts_t sts;

  far_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  far_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .req(in), .cmd(cmd), .sts(sts), .rsp(out)
  );

endmodule
